// ----- src/lge_pkg.sv -----
`timescale 1ns / 1ps

package lge_pkg;

  localparam int MAX_ROWS_DEF = 64;
  localparam int MAX_COLS_DEF = 64;

  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;

  localparam logic [CFG_W-1:0] DIM_RESET = 7'd64;

  localparam logic [1:0] CMD_WRITE   = 2'd0;
  localparam logic [1:0] CMD_READ    = 2'd1;
  localparam logic [1:0] CMD_ADVANCE = 2'd2;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [1:0] command;
    logic [5:0] row;
    logic [5:0] col;
    logic       alive;
  } life_in_t;

  typedef struct packed {
    logic cell_alive;
    logic done_res;
  } life_out_t;

endpackage

// ----- src/lge_ram.sv -----
`timescale 1ns / 1ps

module lge_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/life_generation_engine.sv -----
// sequence: a read or write goes from S_IDLE through S_ACCESS to S_FINISH, an unknown
//   command or an address outside storage straight to S_FINISH; an advance walks S_ADV,
//   one whole row word read and one written per cycle through the two row memories,
//   then S_FINISH, held until the result slot is free; a new item waits for S_IDLE
// reset: synchronous; afterwards a clearing pass zeroes the board,
//   no word is accepted meanwhile, config writes are taken throughout
`timescale 1ns / 1ps

module life_generation_engine
  import lge_pkg::*;
#(
  parameter int MAX_ROWS = MAX_ROWS_DEF,
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  life_in_t             in_word,
  output logic                 out_valid,
  input  logic                 out_ready,
  output life_out_t            out_word
);

  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_ROWS + 2);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_ACCESS = 5'b00100,
    S_ADV    = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t             state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_m1, cnt_m2;
  logic               cur;
  logic [CFG_W-1:0]   rows_in_use, cols_in_use;
  life_in_t           item;
  logic               item_in;
  life_out_t          res;
  logic [MAX_COLS-1:0] top, mid;

  logic                in_fire, slot_free, in_storage;
  logic [MAX_COLS-1:0] col_mask, bot, next_row, rd_word, rd0, rd1, mod_word;
  logic [MAX_COLS+1:0] top_x, mid_x, bot_x;
  logic                in_on, out_on;
  logic [RW-1:0]       raddr, wr_addr;
  logic                wr_en, wr_bank;
  logic [MAX_COLS-1:0] wr_data;
  logic [CW-1:0]       col_idx;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign slot_free  = !out_valid || out_ready;
  assign in_storage = (32'(in_word.row) < MAX_ROWS) && (32'(in_word.col) < MAX_COLS);
  assign col_idx    = CW'(item.col);

  assign cnt_m1 = cnt - CNT_W'(1);
  assign cnt_m2 = cnt - CNT_W'(2);

  assign in_on  = (cnt != '0) && (32'(cnt_m1) < MAX_ROWS)
                  && ((cnt_m1 == '0) || (32'(cnt_m1) < 32'(rows_in_use)));
  assign out_on = (32'(cnt) >= 2) && (32'(cnt_m2) < MAX_ROWS)
                  && ((cnt_m2 == '0) || (32'(cnt_m2) < 32'(rows_in_use)));

  assign rd_word = cur ? rd1 : rd0;
  assign bot     = in_on ? (rd_word & col_mask) : '0;
  assign top_x   = {1'b0, top, 1'b0};
  assign mid_x   = {1'b0, mid, 1'b0};
  assign bot_x   = {1'b0, bot, 1'b0};

  for (genvar c = 0; c < MAX_COLS; c++) begin : g_lane
    logic [3:0] n;
    assign col_mask[c] = (c == 0) || (c < int'(cols_in_use));
    assign n = 4'(top_x[c]) + 4'(top_x[c+1]) + 4'(top_x[c+2]) + 4'(mid_x[c])
             + 4'(mid_x[c+2]) + 4'(bot_x[c]) + 4'(bot_x[c+1]) + 4'(bot_x[c+2]);
    assign next_row[c] = col_mask[c] && out_on && ((n == 4'd3) || (mid[c] && (n == 4'd2)));
  end

  always_comb begin
    mod_word          = rd_word;
    mod_word[col_idx] = item.alive;
  end

  // memory port steering
  always_comb begin
    raddr   = cnt[RW-1:0];
    wr_en   = 1'b0;
    wr_bank = cur;
    wr_addr = RW'(item.row);
    wr_data = mod_word;
    case (state)
      S_IDLE: begin
        raddr = RW'(in_word.row);
      end
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_bank = 1'b0;
        wr_addr = cnt[RW-1:0];
        wr_data = '0;
      end
      S_ACCESS: begin
        wr_en = (item.command == CMD_WRITE);
      end
      S_ADV: begin
        wr_en   = (32'(cnt) >= 2);
        wr_bank = !cur;
        wr_addr = RW'(cnt_m2);
        wr_data = next_row;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  lge_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank0 (
    .clk   (clk),
    .we    (wr_en && !wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd0)
  );

  lge_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bank1 (
    .clk   (clk),
    .we    (wr_en && wr_bank),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (raddr),
    .rdata (rd1)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (32'(cnt) == MAX_ROWS - 1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (in_word.command == CMD_ADVANCE) begin
            state_next = S_ADV;
          end else if ((in_word.command == CMD_WRITE || in_word.command == CMD_READ)
                       && in_storage) begin
            state_next = S_ACCESS;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_ACCESS: begin
        state_next = S_FINISH;
      end
      S_ADV: begin
        if (32'(cnt) == MAX_ROWS + 1) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      cnt         <= '0;
      cur         <= 1'b0;
      rows_in_use <= DIM_RESET;
      cols_in_use <= DIM_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write && cfg_index == REG_ROWS) begin
        rows_in_use <= cfg_data;
      end
      if (cfg_write && cfg_index == REG_COLS) begin
        cols_in_use <= cfg_data;
      end
      case (state)
        S_CLEAR: begin
          cnt <= cnt + CNT_W'(1);
        end
        S_IDLE: begin
          cnt <= '0;
        end
        S_ADV: begin
          cnt <= cnt + CNT_W'(1);
          if (32'(cnt) == MAX_ROWS + 1) begin
            cur <= !cur;
          end
        end
        default: begin
          cnt <= cnt;
        end
      endcase
      if (state == S_FINISH && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item    <= in_word;
      item_in <= in_storage;
      top     <= '0;
      mid     <= '0;
      res.cell_alive <= 1'b0;
      res.done_res   <= (in_word.command != CMD_UNKNOWN);
    end
    if (state == S_ADV) begin
      top <= mid;
      mid <= bot;
    end
    if (state == S_ACCESS && item.command == CMD_READ && item_in) begin
      res.cell_alive <= rd_word[col_idx];
    end
    if (state == S_FINISH && slot_free) begin
      out_word <= res;
    end
  end

`ifndef SYNTH
  a_bank_split: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV && wr_en) |-> (wr_bank != cur))
    else $error("advance writes into the bank being read");

  a_adv_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADV) |-> (32'(cnt) <= MAX_ROWS + 1))
    else $error("advance row counter overran");

  a_flip_only_adv: assert property (@(posedge clk) disable iff (rst)
    ($past(!rst) && (cur != $past(cur))) |-> $past(state == S_ADV))
    else $error("bank select changed outside an advance");

  a_result_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && slot_free) |=> (out_valid && state == S_IDLE))
    else $error("finished word not presented");
`endif

endmodule

// ----- tb/life_generation_engine_checker.sv -----
`timescale 1ns / 1ps

module life_generation_engine_checker
  import lge_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  life_in_t             in_word,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  life_out_t            out_word,
  output int                   fail_count,
  output int                   pending,
  output int                   compared
);

  logic [MAX_COLS_DEF-1:0] board [MAX_ROWS_DEF];
  logic [CFG_W-1:0]        rows_reg;
  logic [CFG_W-1:0]        cols_reg;
  life_out_t               due_results [$];
  int                      misses;
  int                      matched;

  function automatic int clamp_dim(logic [CFG_W-1:0] v, int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  function automatic logic live_at(int r, int c, int nr, int nc);
    if (r < 0 || c < 0 || r >= nr || c >= nc) return 1'b0;
    return board[r][c];
  endfunction

  function automatic void evolve_board();
    logic [MAX_COLS_DEF-1:0] nxt [MAX_ROWS_DEF];
    int nr, nc, r, c, dr, dc, n;
    nr = clamp_dim(rows_reg, MAX_ROWS_DEF);
    nc = clamp_dim(cols_reg, MAX_COLS_DEF);
    for (r = 0; r < MAX_ROWS_DEF; r++) begin
      nxt[r] = '0;
      for (c = 0; c < MAX_COLS_DEF; c++) begin
        if (r < nr && c < nc) begin
          n = 0;
          for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
              if (dr != 0 || dc != 0) n += live_at(r + dr, c + dc, nr, nc);
            end
          end
          nxt[r][c] = (n == 3) || (board[r][c] && n == 2);
        end
      end
    end
    for (r = 0; r < MAX_ROWS_DEF; r++) board[r] = nxt[r];
  endfunction

  function automatic life_out_t resolve_command(life_in_t w);
    life_out_t res;
    res.cell_alive = 1'b0;
    res.done_res   = 1'b1;
    case (w.command)
      CMD_WRITE:   board[w.row][w.col] = w.alive;
      CMD_READ:    res.cell_alive = board[w.row][w.col];
      CMD_ADVANCE: evolve_board();
      default:     res.done_res = 1'b0;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    life_out_t want;
    int r;
    if (rst) begin
      for (r = 0; r < MAX_ROWS_DEF; r++) board[r] = '0;
      rows_reg = DIM_RESET;
      cols_reg = DIM_RESET;
      due_results.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_ROWS: rows_reg = cfg_data;
          REG_COLS: cols_reg = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) due_results.push_back(resolve_command(in_word));
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          $error("result word with nothing pending: cell_alive %0b done_res %0b",
                 out_word.cell_alive, out_word.done_res);
          misses++;
        end else begin
          want = due_results.pop_front();
          if (out_word.cell_alive !== want.cell_alive) begin
            $error("cell_alive expected %0b actual %0b", want.cell_alive, out_word.cell_alive);
            misses++;
          end
          if (out_word.done_res !== want.done_res) begin
            $error("done_res expected %0b actual %0b", want.done_res, out_word.done_res);
            misses++;
          end
          matched++;
        end
      end
    end
    fail_count <= misses;
    pending    <= due_results.size();
    compared   <= matched;
  end

endmodule

// ----- tb/life_generation_engine_tb.sv -----
`timescale 1ns / 1ps

module life_generation_engine_tb
  import lge_pkg::*;
();

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B  = 2'd3;
  localparam int                   CYCLE_LIMIT  = 400000;
  localparam int                   DRAIN_CYCLES = MAX_ROWS_DEF + 8;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  life_in_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  life_out_t            out_word;

  int fail_count;
  int pending;
  int compared;

  int area_rows;
  int area_cols;
  int burst_left;
  int cycle_count;
  int rx_mode;
  int rx_span;
  int n_writes;
  int n_reads;
  int n_advances;
  int n_unknown;
  int n_settings;

  life_generation_engine u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  life_generation_engine_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word),
    .fail_count (fail_count),
    .pending    (pending),
    .compared   (compared)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (rx_span == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_span = $urandom_range(10, 120);
    end
    rx_span--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 1) == 1);
      2: out_ready <= ($urandom_range(0, 7) == 0);
      default: out_ready <= ((rx_span % 40) >= 30);
    endcase
  end

  function automatic life_in_t word_of(logic [1:0] cmd, int r, int c, logic a);
    life_in_t w;
    w.command = cmd;
    w.row     = r[5:0];
    w.col     = c[5:0];
    w.alive   = a;
    return w;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return CFG_W'($urandom_range(65, 127));
      2: return DIM_RESET;
      default: return CFG_W'($urandom_range(2, 10));
    endcase
  endfunction

  task automatic push_word(life_in_t w);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (w.command)
      CMD_WRITE:   n_writes++;
      CMD_READ:    n_reads++;
      CMD_ADVANCE: n_advances++;
      default:     n_unknown++;
    endcase
    burst_left--;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 90) : $urandom_range(0, 5);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic go_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_grid(logic [CFG_W-1:0] rows_v, logic [CFG_W-1:0] cols_v);
    go_idle();
    write_reg(REG_ROWS, rows_v);
    write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom));
    write_reg(REG_COLS, cols_v);
    area_rows = (rows_v == 0) ? 1 : (rows_v > MAX_ROWS_DEF) ? MAX_ROWS_DEF : rows_v;
    area_cols = (cols_v == 0) ? 1 : (cols_v > MAX_COLS_DEF) ? MAX_COLS_DEF : cols_v;
    n_settings++;
  endtask

  initial begin
    int p, k, sel, r, c;
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    in_word   = '0;
    burst_left = 4;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    set_grid(DIM_RESET, DIM_RESET);
    push_word(word_of(CMD_WRITE, 0, 0, 1'b1));
    push_word(word_of(CMD_WRITE, 63, 63, 1'b1));
    push_word(word_of(CMD_READ, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 63, 63, 1'b0));
    push_word(word_of(CMD_READ, 0, 63, 1'b0));
    push_word(word_of(CMD_ADVANCE, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 0, 0, 1'b0));
    // blinker against the top border
    push_word(word_of(CMD_WRITE, 0, 0, 1'b1));
    push_word(word_of(CMD_WRITE, 0, 1, 1'b1));
    push_word(word_of(CMD_WRITE, 0, 2, 1'b1));
    push_word(word_of(CMD_ADVANCE, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 1, 1, 1'b0));
    push_word(word_of(CMD_ADVANCE, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 0, 2, 1'b0));
    push_word(word_of(CMD_UNKNOWN, 63, 63, 1'b1));
    push_word(word_of(CMD_READ, 63, 63, 1'b0));

    // stored cell outside the active area
    set_grid(7'd3, 7'd3);
    push_word(word_of(CMD_WRITE, 10, 10, 1'b1));
    push_word(word_of(CMD_READ, 10, 10, 1'b0));
    push_word(word_of(CMD_ADVANCE, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 10, 10, 1'b0));
    push_word(word_of(CMD_READ, 1, 1, 1'b0));

    // out of range register values
    set_grid(7'd0, 7'd127);
    push_word(word_of(CMD_WRITE, 0, 5, 1'b1));
    push_word(word_of(CMD_WRITE, 0, 6, 1'b1));
    push_word(word_of(CMD_ADVANCE, 0, 0, 1'b0));
    push_word(word_of(CMD_READ, 0, 5, 1'b0));

    for (p = 0; p < 6; p++) begin
      case (p)
        0: set_grid(DIM_RESET, DIM_RESET);
        1: set_grid(7'd1, 7'd1);
        2: set_grid(7'd127, 7'd0);
        default: set_grid(pick_dim(), pick_dim());
      endcase
      for (k = 0; k < 20; k++) begin
        r   = $urandom_range(0, area_rows - 1);
        c   = $urandom_range(0, area_cols - 1);
        sel = $urandom_range(0, 99);
        if (sel < 40) begin
          push_word(word_of(CMD_WRITE, r, c, $urandom_range(0, 99) < 45));
        end else if (sel < 52) begin
          push_word(word_of(CMD_ADVANCE, $urandom, $urandom, 1'($urandom)));
        end else if (sel < 80) begin
          push_word(word_of(CMD_READ, r, c, 1'($urandom)));
        end else if (sel < 92) begin
          push_word(word_of($urandom_range(0, 1) ? CMD_WRITE : CMD_READ,
                            $urandom_range(0, 63), $urandom_range(0, 63), 1'($urandom)));
        end else begin
          push_word(word_of(CMD_UNKNOWN, $urandom, $urandom, 1'($urandom)));
        end
        if ($urandom_range(0, 39) == 0) go_idle();
      end
    end

    go_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("run covered %0d writes, %0d reads, %0d advances and %0d unknown commands",
             n_writes, n_reads, n_advances, n_unknown);
    $display("over %0d grid settings, %0d result words compared", n_settings, compared);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/lge_pkg.sv
src/lge_ram.sv
src/life_generation_engine.sv
tb/life_generation_engine_checker.sv
tb/life_generation_engine_tb.sv
